>>> sv/lnos_pkg.sv
// ----------------------------------------------------------------------------
// lnos_pkg
// Shared constants, types and the gradient table of the lattice noise block.
// ----------------------------------------------------------------------------
package lnos_pkg;

  localparam int PERM_SIZE = 4096;
  localparam int PERM_W    = $clog2(PERM_SIZE);
  // An axis position is kept modulo PERM_SIZE lattice cells of 16 fraction bits.
  localparam int POS_W     = PERM_W + 16;
  localparam logic [PERM_W-1:0] LATTICE_OFS = PERM_W'(1000000 % PERM_SIZE);

  localparam int DEF_MAX_OCTAVES = 16;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_NOISE = 2'd1;
  localparam logic [1:0] FUNC_TURB  = 2'd2;
  localparam logic [1:0] FUNC_FBM   = 2'd3;

  localparam logic [1:0] CFG_OCTAVES = 2'd0;
  localparam logic [1:0] CFG_LACUN   = 2'd1;
  localparam logic [1:0] CFG_GAIN    = 2'd2;

  localparam int SW_W    = 17;
  localparam int OFF_W   = 18;
  localparam int GRAD_W  = 17;
  localparam int D16_W   = 20;
  localparam int PROD_W  = 52;
  localparam int NOISE_W = 20;

  typedef struct packed {
    logic [1:0]        func;
    logic [POS_W-1:0]  r_x;
    logic [POS_W-1:0]  r_y;
    logic [POS_W-1:0]  r_z;
    logic [PERM_W-1:0] entry_index;
    logic [PERM_W-1:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [SW_W-1:0]         sw_x;
    logic [SW_W-1:0]         sw_y;
    logic [SW_W-1:0]         sw_z;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
    logic [7:0]              m;
  } corner_t;

  typedef struct packed {
    logic take;
    logic deliver;
  } core_stat_t;

  // Reflected CRC-16 table entry, polynomial 0xA001.
  function automatic logic [15:0] crc_rom(input logic [7:0] idx);
    logic [15:0] crc;
    crc = {8'h00, idx};
    for (int b = 0; b < 8; b++) begin
      crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    return crc;
  endfunction

  // Gradient 2*rom - 65536, i.e. rom/32768 - 1 in Q16.
  function automatic logic signed [GRAD_W-1:0] grad_val(input logic [7:0] idx);
    logic [15:0] w;
    w = crc_rom(idx);
    return {~w[15], w[14:0], 1'b0};
  endfunction

endpackage

>>> sv/lnos_front.sv
// ----------------------------------------------------------------------------
// lnos_front
// Accepts items, reduces positions to lattice residues and queues them.
// ----------------------------------------------------------------------------
module lnos_front import lnos_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [11:0]        in_entry_index,
  input  logic [11:0]        in_entry_value,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push_ok, pop_ok;

  // The noise repeats every PERM_SIZE cells, so the low bits of the two's
  // complement position are its non-negative residue.
  always_comb begin
    cls.func        = in_func;
    cls.r_x         = in_pos_x[POS_W-1:0];
    cls.r_y         = in_pos_y[POS_W-1:0];
    cls.r_z         = in_pos_z[POS_W-1:0];
    cls.entry_index = in_entry_index;
    cls.entry_value = in_entry_value;
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rp_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/lnos_corner.sv
// ----------------------------------------------------------------------------
// lnos_corner
// Four-stage pipeline: weight and gradient dot product of one lattice corner.
// ----------------------------------------------------------------------------
module lnos_corner import lnos_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     c_valid,
  input  corner_t                  c_in,
  output logic                     p_valid,
  output logic signed [PROD_W-1:0] p_prod
);

  logic [3:0] v_r;

  logic signed [GRAD_W-1:0] g0_r, g1_r, g2_r, g3_r;
  logic [2*SW_W-1:0]        wa_r;
  logic [SW_W-1:0]          sz_r;
  logic signed [OFF_W-1:0]  ox_r, oy_r, oz_r;

  logic signed [34:0]       p0_r, p1_r, p2_r, p3_r;
  logic [3*SW_W-1:0]        w3_r;

  logic signed [D16_W-1:0]  d16_r;
  logic [32:0]              w_r;

  logic signed [PROD_W-1:0] prod_r;

  logic signed [35:0] dsum;
  logic [35:0]        dmag;
  logic [19:0]        dq;
  logic [3*SW_W-1:0]  wround;
  logic signed [53:0] pfull;

  always_comb begin
    dsum   = 36'(p0_r) + 36'(p1_r) + 36'(p2_r) + 36'(p3_r);
    dmag   = dsum[35] ? 36'(-dsum) : dsum;
    dq     = 20'((dmag + 36'h8000) >> 16);
    wround = w3_r + (3*SW_W)'(16'h8000);
    pfull  = $signed({1'b0, w_r}) * d16_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 4'd0;
    end else begin
      v_r <= {v_r[2:0], c_valid};
    end
  end

  always_ff @(posedge clk) begin
    g0_r <= grad_val(c_in.m);
    g1_r <= grad_val(c_in.m + 8'd1);
    g2_r <= grad_val(c_in.m + 8'd2);
    g3_r <= grad_val(c_in.m + 8'd3);
    wa_r <= c_in.sw_x * c_in.sw_y;
    sz_r <= c_in.sw_z;
    ox_r <= c_in.off_x;
    oy_r <= c_in.off_y;
    oz_r <= c_in.off_z;

    p0_r <= 35'(g0_r) <<< 15;
    p1_r <= g1_r * ox_r;
    p2_r <= g2_r * oy_r;
    p3_r <= g3_r * oz_r;
    w3_r <= (3*SW_W)'(wa_r * sz_r);

    d16_r <= dsum[35] ? -$signed(dq) : $signed(dq);
    w_r   <= wround[48:16];

    prod_r <= PROD_W'(pfull);
  end

  assign p_valid = v_r[3];
  assign p_prod  = prod_r;

endmodule

>>> sv/lnos_core.sv
// ----------------------------------------------------------------------------
// lnos_core
// Back end: permutation memory, corner hashing, octave loop and result register.
// ----------------------------------------------------------------------------
module lnos_core import lnos_pkg::*; #(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic [4:0]         octave_count,
  input  logic [23:0]        lacunarity,
  input  logic [23:0]        octave_gain,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_noise_value,
  output core_stat_t         stat
);

  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W  = 55;
  localparam int TSUM_W = 24;
  localparam int FSUM_W = 44;
  localparam logic signed [FSUM_W-1:0] FS_MAX = FSUM_W'(64'sd2147483647);
  localparam logic signed [FSUM_W-1:0] FS_MIN = -FS_MAX - FSUM_W'(1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SM1  = 4'd1;
  localparam logic [3:0] ST_SM2  = 4'd2;
  localparam logic [3:0] ST_SM3  = 4'd3;
  localparam logic [3:0] ST_HX   = 4'd4;
  localparam logic [3:0] ST_HY   = 4'd5;
  localparam logic [3:0] ST_HZ   = 4'd6;
  localparam logic [3:0] ST_WAIT = 4'd7;
  localparam logic [3:0] ST_END1 = 4'd8;
  localparam logic [3:0] ST_END2 = 4'd9;
  localparam logic [3:0] ST_END3 = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0] state_r, state_nxt;

  logic [PERM_W-1:0] perm_mem [PERM_SIZE];
  logic [PERM_W-1:0] rd_r, rd_addr;

  logic [1:0]              mode_r;
  logic [OCT_W-1:0]        noct_r, oct_i_r, noct_in;
  logic [2:0][POS_W-1:0]   r_r;
  logic [2:0][31:0]        ff_r;
  logic [2:0][49:0]        num_r;
  logic [2:0][SW_W-1:0]    sw0_r, sw1_r;
  logic [3:0]              c_r, done_r;
  logic                    m_pend_r;
  logic                    cv_r;
  corner_t                 corner_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [NOISE_W-1:0] n_r;
  logic [TSUM_W-1:0]       tsum_r;
  logic signed [FSUM_W-1:0] fsum_r;
  logic [31:0]             amp_r;
  logic signed [52:0]      tp_r;
  logic [55:0]             ap_r;
  logic [2:0][51:0]        rp_r;
  logic                    out_full_r;
  logic signed [31:0]      out_val_r;

  logic                    p_valid;
  logic signed [PROD_W-1:0] p_prod;

  logic [2:0][15:0]        fr;
  logic [2:0][PERM_W-1:0]  idx0, idx1;
  logic [2:0]              cb;
  logic                    last_oct, take, deliver, pop_ok;
  logic [ACC_W-1:0]        amag;
  logic [NOISE_W-1:0]      aq, nmag;
  logic [31:0]             half, tterm;
  logic [52:0]             tmag;
  logic [36:0]             tq;
  logic [55:0]             aprnd;
  logic signed [31:0]      res;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fr[a]   = r_r[a][15:0];
      idx0[a] = r_r[a][POS_W-1:16] + LATTICE_OFS;
      idx1[a] = idx0[a] + PERM_W'(1);
    end
    cb = 3'(c_r - 4'd1);
  end

  // Three chained reads per corner share the one read port.
  always_comb begin
    case (state_r)
      ST_HY:   rd_addr = rd_r ^ (c_r[1] ? idx1[1] : idx0[1]);
      ST_HZ:   rd_addr = rd_r ^ (c_r[2] ? idx1[2] : idx0[2]);
      default: rd_addr = c_r[0] ? idx1[0] : idx0[0];
    endcase
  end

  always_comb begin
    if (q_item.func == FUNC_NOISE) begin
      noct_in = OCT_W'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      noct_in = OCT_W'(MAX_OCTAVES);
    end else begin
      noct_in = OCT_W'(octave_count);
    end
  end

  always_comb begin
    pop_ok   = out_pop && out_full_r;
    take     = (state_r == ST_IDLE) && q_valid;
    deliver  = (state_r == ST_OUT) && (!out_full_r || out_pop);
    last_oct = ({1'b0, oct_i_r} + (OCT_W+1)'(1)) == {1'b0, noct_r};

    amag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    aq   = NOISE_W'((amag + ACC_W'(33'h080000000)) >> 32);

    nmag  = n_r[NOISE_W-1] ? NOISE_W'(-n_r) : NOISE_W'(n_r);
    half  = (32'd1 << oct_i_r) >> 1;
    tterm = ({{(32-NOISE_W){1'b0}}, nmag} + half) >> oct_i_r;

    tmag  = tp_r[52] ? 53'(-tp_r) : 53'(tp_r);
    tq    = 37'((tmag + 53'h8000) >> 16);
    aprnd = ap_r + 56'h8000;

    case (mode_r)
      FUNC_TURB: res = (tsum_r > TSUM_W'(65536)) ? 32'sd65536 : $signed({8'h00, tsum_r});
      FUNC_FBM: begin
        if (fsum_r > FS_MAX) begin
          res = 32'sh7FFFFFFF;
        end else if (fsum_r < FS_MIN) begin
          res = 32'sh80000000;
        end else begin
          res = 32'(fsum_r);
        end
      end
      default:   res = 32'(n_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.func != FUNC_LOAD) begin
          state_nxt = (noct_in == '0) ? ST_OUT : ST_SM1;
        end
      end
      ST_SM1:  state_nxt = ST_SM2;
      ST_SM2:  state_nxt = ST_SM3;
      ST_SM3:  state_nxt = ST_HX;
      ST_HX:   state_nxt = (c_r == 4'd8) ? ST_WAIT : ST_HY;
      ST_HY:   state_nxt = ST_HZ;
      ST_HZ:   state_nxt = ST_HX;
      ST_WAIT: state_nxt = (done_r == 4'd8) ? ST_END1 : ST_WAIT;
      ST_END1: state_nxt = (mode_r == FUNC_NOISE) ? ST_OUT : ST_END2;
      ST_END2: begin
        if (mode_r == FUNC_FBM) begin
          state_nxt = ST_END3;
        end else begin
          state_nxt = last_oct ? ST_OUT : ST_SM1;
        end
      end
      ST_END3: state_nxt = last_oct ? ST_OUT : ST_SM1;
      ST_OUT:  state_nxt = deliver ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Permutation memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (take && q_item.func == FUNC_LOAD) begin
      perm_mem[q_item.entry_index] <= q_item.entry_value;
    end
    rd_r <= perm_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      c_r        <= 4'd0;
      done_r     <= 4'd0;
      m_pend_r   <= 1'b0;
      cv_r       <= 1'b0;
      out_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cv_r    <= (state_r == ST_HX) && m_pend_r;
      if (state_r == ST_SM3) begin
        c_r      <= 4'd0;
        done_r   <= 4'd0;
        m_pend_r <= 1'b0;
      end else begin
        if (state_r == ST_HZ) begin
          c_r      <= c_r + 4'd1;
          m_pend_r <= 1'b1;
        end else if (state_r == ST_HX) begin
          m_pend_r <= 1'b0;
        end
        if (p_valid) begin
          done_r <= done_r + 4'd1;
        end
      end
      if (deliver) begin
        out_full_r <= 1'b1;
      end else if (pop_ok) begin
        out_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r  <= q_item.func;
      noct_r  <= noct_in;
      oct_i_r <= '0;
      r_r     <= {q_item.r_z, q_item.r_y, q_item.r_x};
      amp_r   <= 32'd65536;
      tsum_r  <= '0;
      fsum_r  <= '0;
      n_r     <= '0;
    end

    for (int a = 0; a < 3; a++) begin
      ff_r[a]  <= fr[a] * fr[a];
      num_r[a] <= ff_r[a] * (18'd196608 - {1'b0, fr[a], 1'b0});
      rp_r[a]  <= r_r[a] * lacunarity;
    end

    // Smoothstep weight of the upper and the lower lattice neighbor.
    if (state_r == ST_SM3) begin
      for (int a = 0; a < 3; a++) begin
        sw1_r[a] <= SW_W'((num_r[a] + 50'h080000000) >> 32);
        sw0_r[a] <= SW_W'(65536) - SW_W'((num_r[a] + 50'h080000000) >> 32);
      end
    end

    corner_r.sw_x  <= cb[0] ? sw1_r[0] : sw0_r[0];
    corner_r.sw_y  <= cb[1] ? sw1_r[1] : sw0_r[1];
    corner_r.sw_z  <= cb[2] ? sw1_r[2] : sw0_r[2];
    corner_r.off_x <= cb[0] ? $signed({2'b11, fr[0]}) : $signed({2'b00, fr[0]});
    corner_r.off_y <= cb[1] ? $signed({2'b11, fr[1]}) : $signed({2'b00, fr[1]});
    corner_r.off_z <= cb[2] ? $signed({2'b11, fr[2]}) : $signed({2'b00, fr[2]});
    corner_r.m     <= rd_r[7:0];

    if (state_r == ST_SM3) begin
      acc_r <= '0;
    end else if (p_valid) begin
      acc_r <= acc_r + ACC_W'(p_prod);
    end

    if (state_r == ST_END1) begin
      n_r <= acc_r[ACC_W-1] ? -$signed(aq) : $signed(aq);
    end

    tp_r <= n_r * $signed({1'b0, amp_r});
    ap_r <= amp_r * octave_gain;

    if (state_r == ST_END2 && mode_r == FUNC_TURB) begin
      tsum_r <= tsum_r + TSUM_W'(tterm);
      for (int a = 0; a < 3; a++) begin
        r_r[a] <= {r_r[a][POS_W-2:0], 1'b0};
      end
    end

    if (state_r == ST_END3) begin
      fsum_r <= fsum_r + (tp_r[52] ? -FSUM_W'(tq) : FSUM_W'(tq));
      amp_r  <= (aprnd[55:48] != 8'h00) ? 32'hFFFFFFFF : aprnd[47:16];
      for (int a = 0; a < 3; a++) begin
        r_r[a] <= rp_r[a][POS_W+15:16];
      end
    end

    if ((state_r == ST_END2 && mode_r == FUNC_TURB) || state_r == ST_END3) begin
      oct_i_r <= oct_i_r + OCT_W'(1);
    end

    if (deliver) begin
      out_val_r <= res;
    end
  end

  lnos_corner u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .c_valid (cv_r),
    .c_in    (corner_r),
    .p_valid (p_valid),
    .p_prod  (p_prod)
  );

  assign q_pop           = take;
  assign out_empty       = !out_full_r;
  assign out_noise_value = out_val_r;
  assign stat.take       = take;
  assign stat.deliver    = deliver;

endmodule

>>> sv/lattice_noise_octave_sum_top.sv
// ----------------------------------------------------------------------------
// lattice_noise_octave_sum_top
// 3D lattice gradient noise with turbulence and fBm octave sums, Q16.16.
// ----------------------------------------------------------------------------
// Load the permutation table first with load items (one per entry, taken in
// one cycle by the back end). A noise item is worked through one octave,
// turbulence and fBm items through octave_count octaves, capped at
// MAX_OCTAVES. Each octave is dominated by 24 reads of the permutation
// memory, three chained reads for each of the eight lattice corners through
// its single read port, followed by the drain of the four-stage corner
// pipeline. A two-entry queue lets new items be pushed while one is being
// worked on, and the result register holds a finished item until popped.
module lattice_noise_octave_sum_top import lnos_pkg::*; #(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [11:0]        in_entry_index,
  input  logic [11:0]        in_entry_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic [4:0]  octave_count_r;
  logic [23:0] lacunarity_r;
  logic [23:0] octave_gain_r;

  logic       q_valid, q_pop;
  item_t      q_item;
  core_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= 5'd1;
      lacunarity_r   <= 24'd131072;
      octave_gain_r  <= 24'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OCTAVES: octave_count_r <= cfg_data[4:0];
        CFG_LACUN:   lacunarity_r   <= cfg_data;
        CFG_GAIN:    octave_gain_r  <= cfg_data;
        default:     octave_count_r <= octave_count_r;
      endcase
    end
  end

  lnos_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  lnos_core #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .octave_count    (octave_count_r),
    .lacunarity      (lacunarity_r),
    .octave_gain     (octave_gain_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_noise_value (out_noise_value),
    .stat            (stat)
  );

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // Taking an item from the queue frees a slot unless a push lands at once.
  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    stat.take && !(in_push && !in_full) |=> !in_full)
    else $error("queue still full after the back end took an item");

  // A result only appears when the back end delivers one.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(stat.deliver))
    else $error("result appeared without a delivery");

endmodule

>>> bench/lattice_noise_octave_sum_top_tb.sv
// ----------------------------------------------------------------------------
// lattice_noise_octave_sum_top_tb
// Loads a random permutation, then runs directed and random noise, turbulence
// and fBm items over several register settings, with bursty input and a
// stalling consumer. Every result is checked against a fixed-point predictor.
// ----------------------------------------------------------------------------
module lattice_noise_octave_sum_top_tb;
  import lnos_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         TB_MAX_OCT = 16;
  localparam longint     POS_MOD    = longint'(PERM_SIZE) * 65536;
  localparam int         CYCLE_LIMIT = 3000000;

  class noise_scoreboard;
    bit [11:0]   perm [PERM_SIZE];
    bit [15:0]   crc_tab [256];
    int unsigned oct_cfg, lac_cfg, gain_cfg;
    int          noise_q [$];
    int          errors, checked;
    int          func_cnt [4];

    function new();
      bit [15:0] c;
      for (int i = 0; i < 256; i++) begin
        c = 16'(i);
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        crc_tab[i] = c;
      end
      oct_cfg = 1;
      lac_cfg = 131072;
      gain_cfg = 32768;
    endfunction

    function void write_reg(bit [1:0] idx, bit [23:0] v);
      case (idx)
        CFG_OCTAVES: oct_cfg = v[4:0];
        CFG_LACUN:   lac_cfg = v;
        CFG_GAIN:    gain_cfg = v;
        default: ;
      endcase
    endfunction

    function longint round_off(longint v, int k);
      longint unsigned mag, q;
      mag = v < 0 ? longint'(-v) : v;
      q = (mag + ((64'd1 << k) >> 1)) >> k;
      return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint grad_of(int m, int k);
      return 2 * longint'(crc_tab[(m + k) & 255]) - 65536;
    endfunction

    function int lattice_noise(longint unsigned rr [3]);
      int unsigned    ix [3][2];
      longint         offs [3][2];
      longint unsigned wt [3][2];
      longint unsigned f, s, w;
      longint         acc, d;
      int unsigned    h, m;
      int             bx, by, bz;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
        f = rr[a] & 64'hFFFF;
        s = (f * f * (196608 - 2 * f) + 64'h80000000) >> 32;
        ix[a][0] = (int'(rr[a] >> 16) + int'(LATTICE_OFS)) % PERM_SIZE;
        ix[a][1] = (ix[a][0] + 1) % PERM_SIZE;
        offs[a][0] = longint'(f);
        offs[a][1] = longint'(f) - 65536;
        wt[a][0] = 65536 - s;
        wt[a][1] = s;
      end
      for (int c = 0; c < 8; c++) begin
        bx = c & 1;
        by = (c >> 1) & 1;
        bz = (c >> 2) & 1;
        h = perm[ix[0][bx]];
        h = perm[(h ^ ix[1][by]) % PERM_SIZE];
        m = perm[(h ^ ix[2][bz]) % PERM_SIZE] & 8'hFF;
        w = (wt[0][bx] * wt[1][by] * wt[2][bz] + 32768) >> 16;
        d = grad_of(m, 0) * 32768 + grad_of(m, 1) * offs[0][bx]
          + grad_of(m, 2) * offs[1][by] + grad_of(m, 3) * offs[2][bz];
        acc += longint'(w) * round_off(d, 16);
      end
      return int'(round_off(acc, 32));
    endfunction

    function void note_item(bit [1:0] func, int px, int py, int pz,
                            bit [11:0] ei, bit [11:0] ev);
      longint unsigned rr [3];
      longint          q, res;
      longint unsigned t, amp, mag;
      int              p [3];
      int              oct, n;
      func_cnt[func]++;
      if (func == FUNC_LOAD) begin
        perm[ei] = ev;
        return;
      end
      p[0] = px; p[1] = py; p[2] = pz;
      for (int a = 0; a < 3; a++) begin
        q = longint'(p[a]) % POS_MOD;
        if (q < 0) q += POS_MOD;
        rr[a] = q;
      end
      oct = oct_cfg > TB_MAX_OCT ? TB_MAX_OCT : oct_cfg;
      res = 0;
      case (func)
        FUNC_NOISE: res = lattice_noise(rr);
        FUNC_TURB: begin
          t = 0;
          for (int i = 0; i < oct; i++) begin
            n = lattice_noise(rr);
            mag = n < 0 ? longint'(-longint'(n)) : longint'(n);
            t += (mag + ((64'd1 << i) >> 1)) >> i;
            for (int a = 0; a < 3; a++) rr[a] = (rr[a] * 2) % POS_MOD;
          end
          res = t > 65536 ? 65536 : longint'(t);
        end
        default: begin
          amp = 65536;
          for (int i = 0; i < oct; i++) begin
            n = lattice_noise(rr);
            res += round_off(longint'(n) * longint'(amp), 16);
            amp = (amp * gain_cfg + 32768) >> 16;
            if (amp > 64'hFFFFFFFF) amp = 64'hFFFFFFFF;
            for (int a = 0; a < 3; a++) rr[a] = ((rr[a] * lac_cfg) >> 16) % POS_MOD;
          end
        end
      endcase
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      noise_q.push_back(int'(res));
    endfunction

    function void check_result(int got);
      int want;
      checked++;
      if (noise_q.size() == 0) begin
        $error("noise_value %0d arrived with no item outstanding", got);
        errors++;
        return;
      end
      want = noise_q.pop_front();
      if (got !== want) begin
        $error("noise_value mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_func = FUNC_LOAD;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [11:0]        in_entry_index = '0, in_entry_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_noise_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_OCTAVES;
  logic [23:0]        cfg_data = '0;

  noise_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 4;
  int pop_style = 0, pop_left = 50;

  lattice_noise_octave_sum_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Observe handshakes with the values that stood before the edge.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lattice_noise_octave_sum_top test failed");
      $finish;
    end
    if (rst_n) begin
      if (in_push && !in_full)
        sb.note_item(in_func, in_pos_x, in_pos_y, in_pos_z, in_entry_index, in_entry_value);
      if (out_pop && !out_empty) sb.check_result(out_noise_value);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // The consumer switches between popping freely, popping at random and popping rarely.
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_style = $urandom_range(2, 0);
      pop_left = $urandom_range(300, 20);
    end
    pop_left--;
    case (pop_style)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(1, 0));
      default: out_pop <= ($urandom_range(7, 0) == 0);
    endcase
  end

  task automatic send(bit [1:0] f, int px, int py, int pz, bit [11:0] ei, bit [11:0] ev);
    in_push <= 1'b1;
    in_func <= f;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_entry_index <= ei;
    in_entry_value <= ev;
    do @(posedge clk); while (in_full);
    burst_left--;
    if (burst_left <= 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
    end
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (sb.noise_q.size() != 0) @(posedge clk);
    // A load item may still be in flight without any result to wait for.
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_pos();
    case ($urandom_range(3, 0))
      0: return int'($urandom());
      1: return $signed($urandom_range(2 * 262144, 0)) - 262144;
      2: return int'($urandom()) & 32'hFFFF0000;
      default: return (int'($urandom()) & 32'hFFFF0000) | 32'hFFFF;
    endcase
  endfunction

  task automatic random_items(int count);
    bit [1:0] f;
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(9, 0) == 0) ? FUNC_LOAD : 2'($urandom_range(3, 1));
      send(f, pick_pos(), pick_pos(), pick_pos(), 12'($urandom()), 12'($urandom()));
    end
  endtask

  task automatic set_regs(int unsigned oct, int unsigned lac, int unsigned gain);
    settle();
    write_reg(CFG_OCTAVES, 24'(oct));
    write_reg(CFG_LACUN, 24'(lac));
    write_reg(CFG_GAIN, 24'(gain));
  endtask

  initial begin
    int shuffle [PERM_SIZE];
    int j, tmp;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every table entry gets written once, as a random permutation.
    for (int i = 0; i < PERM_SIZE; i++) shuffle[i] = i;
    for (int i = PERM_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < PERM_SIZE; i++) send(FUNC_LOAD, 0, 0, 0, 12'(i), 12'(shuffle[i]));

    // Directed corners with the reset register values.
    send(FUNC_NOISE, 0, 0, 0, 0, 0);
    send(FUNC_NOISE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0);
    send(FUNC_NOISE, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    send(FUNC_NOISE, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
    send(FUNC_NOISE, 32'h0000FFFF, 32'hFFFF0000, 32'h00010000, 0, 0);
    send(FUNC_NOISE, 32'h00008000, 32'hFFFF8000, 32'h12348000, 0, 0);
    send(FUNC_NOISE, 32'hFFFFFFFF, 32'h00000001, 32'h0FFF0000, 0, 0);
    send(FUNC_TURB, 32'h00018000, 32'h00024000, 32'hFFFE8000, 0, 0);
    send(FUNC_TURB, 32'h80000000, 32'h7FFFFFFF, 32'h0000FFFF, 0, 0);
    send(FUNC_FBM, 32'h00018000, 32'h00024000, 32'hFFFE8000, 0, 0);
    send(FUNC_FBM, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0);
    send(FUNC_LOAD, 0, 0, 0, 12'hFFF, 12'hFFF);
    send(FUNC_LOAD, 0, 0, 0, 12'h000, 12'h000);
    send(FUNC_NOISE, 32'h0FFF0000, 32'h0FFF8000, 0, 0, 0);
    send(FUNC_NOISE, 32'hF0418000, 32'h00000000, 32'h0FFFFFFF, 0, 0);

    // Zero octaves, an ignored register index, then the largest settings.
    set_regs(0, 24'hFFFFFF, 24'hFFFFFF);
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    random_items(20);
    set_regs(16, 24'hFFFFFF, 24'hFFFFFF);
    random_items(12);
    set_regs(31, 0, 0);
    write_reg(CFG_UNUSED, 24'h000000);
    random_items(12);
    set_regs(4, 131072, 65536);
    random_items(40);
    set_regs(2, 131072, 32768);
    random_items(60);
    for (int ph = 0; ph < 8; ph++) begin
      set_regs($urandom_range(5, 1),
               $urandom_range(1, 0) ? $urandom_range(24'hFFFFFF, 0) : $urandom_range(196608, 65536),
               $urandom_range(1, 0) ? $urandom_range(24'hFFFFFF, 0) : $urandom_range(65536, 0));
      random_items(75);
    end

    settle();
    repeat (100) @(posedge clk);
    $display("Covered %0d table loads, %0d noise, %0d turbulence and %0d fBm items;",
             sb.func_cnt[FUNC_LOAD], sb.func_cnt[FUNC_NOISE], sb.func_cnt[FUNC_TURB],
             sb.func_cnt[FUNC_FBM]);
    $display("%0d results compared over a dozen register settings.", sb.checked);
    if (sb.noise_q.size() != 0) begin
      $error("%0d expected noise_value results never arrived", sb.noise_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("lattice_noise_octave_sum_top test passed");
    end else begin
      $display("lattice_noise_octave_sum_top test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lnos_pkg.sv
sv/lnos_front.sv
sv/lnos_corner.sv
sv/lnos_core.sv
sv/lattice_noise_octave_sum_top.sv
bench/lattice_noise_octave_sum_top_tb.sv
